/* sv/mdtp_pkg.sv */
// ----------------------------------------------------------------------------
// mdtp_pkg
// Shared types, register indexes and reset constants of the machine-cycle
// divider, timer and pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdtp_pkg;

    localparam int BASE_CLOCK_DEFAULT       = 4194304;
    localparam int PACES_PER_SECOND_DEFAULT = 1024;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELOAD_VALUE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_SPEED = 3'd4;

    localparam logic [2:0] SPEED_QUARTER  = 3'd0;
    localparam logic [2:0] SPEED_HALF     = 3'd1;
    localparam logic [2:0] SPEED_NORMAL   = 3'd2;
    localparam logic [2:0] SPEED_DOUBLE   = 3'd3;
    localparam logic [2:0] SPEED_FOURFOLD = 3'd4;

    localparam logic [10:0] TIMER_PERIOD_RESET = 11'd1024;
    localparam logic [10:0] CYCLE_CLOCKS_SUB   = 11'd4;
    localparam logic [31:0] CYCLE_CLOCKS       = 32'd4;
    localparam logic [31:0] DIVIDER_STEP       = 32'd256;
    localparam logic [31:0] DIVIDER_MARK_RESET = 32'd256;
    localparam logic [31:0] LAST_CYCLE_COUNT   = 32'hFFFF_FFFC;
    localparam logic [7:0]  COUNTER_MAX        = 8'd255;

    typedef struct packed {
        logic        enable;
        logic [10:0] period;
        logic [7:0]  reload;
    } timer_cfg_t;

endpackage

`default_nettype wire

/* sv/mdtp_timer.sv */
// ----------------------------------------------------------------------------
// mdtp_timer
// Sub-counter and 8-bit timer counter with reload on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_timer
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire mdtp_pkg::timer_cfg_t cfg,
    output logic [7:0]               count_next,
    output logic                     irq_next
);

    logic [10:0] sub_reg;
    logic [10:0] sub_next;
    logic [10:0] sub_sum;
    logic [7:0]  count_reg;

    always_comb
    begin
        sub_sum    = sub_reg + mdtp_pkg::CYCLE_CLOCKS_SUB;
        sub_next   = sub_reg;
        count_next = count_reg;
        irq_next   = 1'b0;
        if (advance && cfg.enable)
        begin
            sub_next = sub_sum;
            if (sub_sum == cfg.period)
            begin
                sub_next = '0;
                if (count_reg == mdtp_pkg::COUNTER_MAX)
                begin
                    count_next = cfg.reload;
                    irq_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sub_reg   <= sub_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mcycle_divider_timer_pacer.sv */
// ----------------------------------------------------------------------------
// mcycle_divider_timer_pacer
// Machine-cycle clock count with divider, timer counter, pacing marks and
// a whole-second counter.
// ----------------------------------------------------------------------------
// A request is taken into the input register; the result register loads from it
// once the result slot is free or out_stall is low.
// Throughput: one request per cycle unless out_stall holds a full result; an input
// register and a result register split the two channels, and all state updates in
// the single step between. Reset: rst_n clears every state, valid and configuration
// register at once to its listed reset value; tick and result data are not reset.
`default_nettype none

module mcycle_divider_timer_pacer
#(
    parameter int BASE_CLOCK       = mdtp_pkg::BASE_CLOCK_DEFAULT,
    parameter int PACES_PER_SECOND = mdtp_pkg::PACES_PER_SECOND_DEFAULT
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             tick,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            divider_value,
    output logic [7:0]                            counter_value,
    output logic                                  timer_interrupt,
    output logic                                  pace_point,
    output logic [31:0]                           seconds_count,
    input  wire logic                             cfg_we,
    input  wire logic [mdtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mdtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [31:0] PACE_BASE  = 32'(BASE_CLOCK / PACES_PER_SECOND);
    localparam logic [31:0] STEP_QUART = PACE_BASE / 32'd4;
    localparam logic [31:0] STEP_HALF  = PACE_BASE / 32'd2;
    localparam logic [31:0] STEP_DBL   = PACE_BASE * 32'd2;
    localparam logic [31:0] STEP_FOUR  = PACE_BASE * 32'd4;
    localparam int          REM_W      = $clog2(2 * BASE_CLOCK + 4);
    localparam logic [REM_W-1:0] RATE1 = REM_W'(BASE_CLOCK);
    localparam logic [REM_W-1:0] RATE2 = REM_W'(2 * BASE_CLOCK);
    localparam logic [REM_W-1:0] REM_STEP = REM_W'(4);

    // configuration
    mdtp_pkg::timer_cfg_t timer_cfg_reg;
    logic [2:0]           speed_reg;
    logic                 dspeed_reg;

    // pipeline
    logic s1_valid_reg;
    logic s1_tick_reg;
    logic s1_adv;
    logic step;

    // state
    logic [31:0]      clock_reg;
    logic [31:0]      clock_next;
    logic [31:0]      pace_mark_reg;
    logic [31:0]      pace_mark_next;
    logic [31:0]      div_mark_reg;
    logic [31:0]      div_mark_next;
    logic [7:0]       divider_reg;
    logic [7:0]       divider_next;
    logic [31:0]      seconds_reg;
    logic [31:0]      seconds_next;
    logic [REM_W-1:0] rem1_reg;
    logic [REM_W-1:0] rem1_next;
    logic [REM_W-1:0] rem2_reg;
    logic [REM_W-1:0] rem2_next;
    logic [REM_W-1:0] rem1_sum;
    logic [REM_W-1:0] rem2_sum;
    logic [31:0]      pace_step;
    logic             pace_next;
    logic [7:0]       count_next;
    logic             irq_next;

    // result
    logic        out_valid_reg;
    logic [7:0]  res_div_reg;
    logic [7:0]  res_cnt_reg;
    logic        res_irq_reg;
    logic        res_pace_reg;
    logic [31:0] res_sec_reg;

    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign step     = s1_adv && s1_tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_cfg_reg.enable <= 1'b0;
            timer_cfg_reg.period <= mdtp_pkg::TIMER_PERIOD_RESET;
            timer_cfg_reg.reload <= '0;
            speed_reg            <= mdtp_pkg::SPEED_NORMAL;
            dspeed_reg           <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mdtp_pkg::CFG_TIMER_ENABLE: timer_cfg_reg.enable <= cfg_data[0];
                mdtp_pkg::CFG_TIMER_PERIOD: timer_cfg_reg.period <= cfg_data[10:0];
                mdtp_pkg::CFG_RELOAD_VALUE: timer_cfg_reg.reload <= cfg_data[7:0];
                mdtp_pkg::CFG_SPEED_MODE:   speed_reg            <= cfg_data[2:0];
                mdtp_pkg::CFG_DOUBLE_SPEED: dspeed_reg           <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (speed_reg)
            mdtp_pkg::SPEED_QUARTER:  pace_step = STEP_QUART;
            mdtp_pkg::SPEED_HALF:     pace_step = STEP_HALF;
            mdtp_pkg::SPEED_DOUBLE:   pace_step = STEP_DBL;
            mdtp_pkg::SPEED_FOURFOLD: pace_step = STEP_FOUR;
            default:                  pace_step = PACE_BASE;
        endcase
        pace_step = pace_step << dspeed_reg;
    end

    always_comb
    begin
        clock_next     = clock_reg;
        pace_mark_next = pace_mark_reg;
        div_mark_next  = div_mark_reg;
        divider_next   = divider_reg;
        seconds_next   = seconds_reg;
        rem1_next      = rem1_reg;
        rem2_next      = rem2_reg;
        pace_next      = 1'b0;
        rem1_sum       = rem1_reg + REM_STEP;
        rem2_sum       = rem2_reg + REM_STEP;
        if (step)
        begin
            clock_next = clock_reg + mdtp_pkg::CYCLE_CLOCKS;
            // track the count modulo both clock rates; the count wrap restarts them
            if (clock_reg == mdtp_pkg::LAST_CYCLE_COUNT)
            begin
                rem1_next = '0;
                rem2_next = '0;
            end
            else
            begin
                rem1_next = (rem1_sum >= RATE1) ? rem1_sum - RATE1 : rem1_sum;
                rem2_next = (rem2_sum >= RATE2) ? rem2_sum - RATE2 : rem2_sum;
            end
            if (clock_next == pace_mark_reg)
            begin
                pace_next      = 1'b1;
                pace_mark_next = pace_mark_reg + pace_step;
                if ((dspeed_reg ? rem2_next : rem1_next) == '0)
                begin
                    seconds_next = seconds_reg + 32'd1;
                end
            end
            if (clock_next == div_mark_reg)
            begin
                div_mark_next = div_mark_reg + mdtp_pkg::DIVIDER_STEP;
                divider_next  = divider_reg + 8'd1;
            end
        end
    end

    mdtp_timer u_timer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (step),
        .cfg        (timer_cfg_reg),
        .count_next (count_next),
        .irq_next   (irq_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clock_reg     <= '0;
            pace_mark_reg <= PACE_BASE;
            div_mark_reg  <= mdtp_pkg::DIVIDER_MARK_RESET;
            divider_reg   <= '0;
            seconds_reg   <= '0;
            rem1_reg      <= '0;
            rem2_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            clock_reg     <= clock_next;
            pace_mark_reg <= pace_mark_next;
            div_mark_reg  <= div_mark_next;
            divider_reg   <= divider_next;
            seconds_reg   <= seconds_next;
            rem1_reg      <= rem1_next;
            rem2_reg      <= rem2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_tick_reg <= tick;
        end
        if (s1_adv)
        begin
            res_div_reg  <= divider_next;
            res_cnt_reg  <= count_next;
            res_irq_reg  <= irq_next;
            res_pace_reg <= pace_next;
            res_sec_reg  <= seconds_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign divider_value   = res_div_reg;
    assign counter_value   = res_cnt_reg;
    assign timer_interrupt = res_irq_reg;
    assign pace_point      = res_pace_reg;
    assign seconds_count   = res_sec_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && s1_valid_reg))
        else $error("input stalled with a free result slot");

    a_divider_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(divider_reg) && $stable(clock_reg))
        else $error("divider or clock count moved without a tick");

    a_idle_no_pace: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_tick_reg) |=> (!pace_point && !timer_interrupt))
        else $error("idle request raised a pulse");

    a_seconds_on_pace: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (seconds_next != seconds_reg)) |-> pace_next)
        else $error("seconds advanced off a pacing point");
`endif

endmodule

`default_nettype wire
